/* hdl/uqd_pkg.sv */
// Shared types, character codes and hex helpers for the query string decoder.
package uqd_pkg;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_END  = 1'b1;

  localparam int MAX_RES = 3;

  typedef logic [1:0] res_cnt_t;

  typedef struct packed {
    logic [7:0] data;
    logic       data_valid;
    logic       in_value;
    logic       pair_end;
    logic       had_equals;
  } res_t;

  localparam res_t RES_NONE = '{data: 8'h00, data_valid: 1'b0, in_value: 1'b0,
                                pair_end: 1'b0, had_equals: 1'b0};

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) ||
           (c >= 8'h41 && c <= 8'h46) ||
           (c >= 8'h61 && c <= 8'h66);
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] v;
    v = 8'h00;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = c - 8'h30;
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v = c - 8'h37;
    end else if (c >= 8'h61 && c <= 8'h66) begin
      v = c - 8'h57;
    end
    return v[3:0];
  endfunction

endpackage

/* hdl/uqd_if.sv */
// Valid/ready channel interfaces for query input items and decoded result items.
interface uqd_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] raw_byte;

  modport source (output valid, output op, output raw_byte, input ready);
  modport sink   (input valid, input op, input raw_byte, output ready);
endinterface

interface uqd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;
  logic       data_valid;
  logic       in_value;
  logic       pair_end;
  logic       had_equals;
  logic       last;

  modport source (output valid, output data, output data_valid, output in_value,
                  output pair_end, output had_equals, output last, input ready);
  modport sink   (input valid, input data, input data_valid, input in_value,
                  input pair_end, input had_equals, input last, output ready);
endinterface

/* hdl/uqd_decode.sv */
// Escape and pair state plus the per-item decode into up to three results.
module uqd_decode (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic                op,
  input  logic [7:0]          raw_byte,
  output uqd_pkg::res_cnt_t   cnt,
  output uqd_pkg::res_t       res [uqd_pkg::MAX_RES]
);

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_PCT   = 2'd1,
    PH_DIGIT = 2'd2
  } phase_t;

  phase_t     phase, phase_next;
  logic [7:0] held, held_next;
  logic       vp, vp_next;

  always_comb begin
    uqd_pkg::res_cnt_t n;
    logic              done;
    phase_t            ph;
    n          = '0;
    done       = 1'b0;
    res        = '{default: uqd_pkg::RES_NONE};
    held_next  = held;
    vp_next    = vp;
    ph         = phase;
    if (phase != PH_PCT && phase != PH_DIGIT) begin
      ph = PH_IDLE;
    end
    phase_next = ph;

    if (op == uqd_pkg::OP_END) begin
      // emit a pending escape literally, then close the pair
      if (ph == PH_PCT || ph == PH_DIGIT) begin
        res[n] = '{data: uqd_pkg::CH_PCT, data_valid: 1'b1, in_value: vp,
                   pair_end: 1'b0, had_equals: 1'b0};
        n = n + 2'd1;
      end
      if (ph == PH_DIGIT) begin
        res[n] = '{data: held, data_valid: 1'b1, in_value: vp,
                   pair_end: 1'b0, had_equals: 1'b0};
        n = n + 2'd1;
      end
      res[n] = '{data: 8'h00, data_valid: 1'b0, in_value: 1'b0,
                 pair_end: 1'b1, had_equals: vp};
      n          = n + 2'd1;
      vp_next    = 1'b0;
      phase_next = PH_IDLE;
      held_next  = 8'h00;
    end else begin
      if (ph == PH_PCT || ph == PH_DIGIT) begin
        if (uqd_pkg::is_hex(raw_byte)) begin
          done = 1'b1;
          if (ph == PH_PCT) begin
            held_next  = raw_byte;
            phase_next = PH_DIGIT;
          end else begin
            res[n] = '{data: {uqd_pkg::hex_val(held), uqd_pkg::hex_val(raw_byte)},
                       data_valid: 1'b1, in_value: vp,
                       pair_end: 1'b0, had_equals: 1'b0};
            n          = n + 2'd1;
            phase_next = PH_IDLE;
            held_next  = 8'h00;
          end
        end else begin
          // malformed escape: drop back to literal text
          res[n] = '{data: uqd_pkg::CH_PCT, data_valid: 1'b1, in_value: vp,
                     pair_end: 1'b0, had_equals: 1'b0};
          n = n + 2'd1;
          if (ph == PH_DIGIT) begin
            res[n] = '{data: held, data_valid: 1'b1, in_value: vp,
                       pair_end: 1'b0, had_equals: 1'b0};
            n = n + 2'd1;
          end
          phase_next = PH_IDLE;
          held_next  = 8'h00;
        end
      end
      if (!done) begin
        priority if (raw_byte == uqd_pkg::CH_PCT) begin
          phase_next = PH_PCT;
        end else if (raw_byte == uqd_pkg::CH_PLUS) begin
          res[n] = '{data: uqd_pkg::CH_SPACE, data_valid: 1'b1, in_value: vp,
                     pair_end: 1'b0, had_equals: 1'b0};
          n = n + 2'd1;
        end else if (raw_byte == uqd_pkg::CH_AMP) begin
          res[n] = '{data: 8'h00, data_valid: 1'b0, in_value: 1'b0,
                     pair_end: 1'b1, had_equals: vp};
          n       = n + 2'd1;
          vp_next = 1'b0;
        end else if (raw_byte == uqd_pkg::CH_EQ && !vp) begin
          vp_next = 1'b1;
        end else begin
          res[n] = '{data: raw_byte, data_valid: 1'b1, in_value: vp,
                     pair_end: 1'b0, had_equals: 1'b0};
          n = n + 2'd1;
        end
      end
    end
    cnt = n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      held  <= 8'h00;
      vp    <= 1'b0;
    end else if (step) begin
      phase <= phase_next;
      held  <= held_next;
      vp    <= vp_next;
    end
  end

endmodule

/* hdl/urlencoded_query_decoder_top.sv */
// Top level of the query string decoder: input register, decode, result buffer.
//
//   port    | dir  | item
//   --------+------+--------------------------------------------------------
//   query   | sink | op, raw_byte: one raw byte or the end of the string
//   result  | src  | data, data_valid, in_value, pair_end, had_equals, last
//
// An accepted item waits in the input register and is decoded in the cycle
// it moves to the result buffer; while result.ready is high its results
// leave one per cycle and items with zero or one result sustain one item per
// cycle; other items hold the input until the single result port drains them.
// Synchronous reset empties both registers and clears the escape/pair state.
// A stalled result holds its buffer; the input register still takes one item.
module urlencoded_query_decoder_top (
  input  logic      clk,
  input  logic      rst,
  uqd_in_if.sink    query,
  uqd_out_if.source result
);

  logic                in_full;
  logic                in_op;
  logic [7:0]          in_byte;

  logic                out_full;
  uqd_pkg::res_cnt_t   buf_cnt;
  uqd_pkg::res_cnt_t   idx;
  uqd_pkg::res_t       buf_res [uqd_pkg::MAX_RES];

  uqd_pkg::res_cnt_t   dec_cnt;
  uqd_pkg::res_t       dec_res [uqd_pkg::MAX_RES];
  uqd_pkg::res_t       cur;

  logic out_fire, out_final, buf_free, move;

  assign out_fire  = out_full && result.ready;
  assign out_final = (idx == buf_cnt - 2'd1);
  assign buf_free  = !out_full || (out_fire && out_final);
  assign move      = in_full && buf_free;

  assign query.ready = !in_full || move;

  uqd_decode u_decode (
    .clk      (clk),
    .rst      (rst),
    .step     (move),
    .op       (in_op),
    .raw_byte (in_byte),
    .cnt      (dec_cnt),
    .res      (dec_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (query.valid && query.ready) begin
      in_full <= 1'b1;
    end else if (move) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (query.valid && query.ready) begin
      in_op   <= query.op;
      in_byte <= query.raw_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
      idx      <= '0;
      buf_cnt  <= '0;
    end else if (move && dec_cnt != 2'd0) begin
      out_full <= 1'b1;
      idx      <= '0;
      buf_cnt  <= dec_cnt;
    end else if (out_fire) begin
      // advance within the batch, or drop it after its final result
      if (out_final) begin
        out_full <= 1'b0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (move && dec_cnt != 2'd0) begin
      buf_res <= dec_res;
    end
  end

  assign cur               = buf_res[idx];
  assign result.valid      = out_full;
  assign result.data       = cur.data;
  assign result.data_valid = cur.data_valid;
  assign result.in_value   = cur.in_value;
  assign result.pair_end   = cur.pair_end;
  assign result.had_equals = cur.had_equals;
  assign result.last       = out_final;

endmodule

/* verif/query_decode_checker.sv */
// Scoreboard for the query string decoder: predicts result items and checks them in order.
module query_decode_checker
  import uqd_pkg::*;
(
  input  logic clk,
  input  logic rst,
  uqd_in_if    query,
  uqd_out_if   result,
  output int   mismatches,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [1:0] {ESC_NONE, ESC_PCT, ESC_DIGIT} esc_phase_t;

  typedef struct packed {
    logic [7:0] data;
    logic       data_valid;
    logic       in_value;
    logic       pair_end;
    logic       had_equals;
    logic       last;
  } decoded_t;

  decoded_t   expected_results[$];
  esc_phase_t esc_phase;
  logic [7:0] held_char;
  logic       in_value_part;

  initial begin
    mismatches = 0;
    pending = 0;
  end

  // Return {is_hex, nibble}.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    if (c >= "0" && c <= "9") begin
      return {1'b1, c[3:0]};
    end
    if ((c >= "A" && c <= "F") || (c >= "a" && c <= "f")) begin
      return {1'b1, c[3:0] + 4'd9};
    end
    return 5'd0;
  endfunction

  function automatic void put_byte(input logic [7:0] b);
    expected_results.push_back('{data: b, data_valid: 1'b1, in_value: in_value_part,
                                 pair_end: 1'b0, had_equals: 1'b0, last: 1'b0});
  endfunction

  // Emit a pending '%' and held digit literally.
  function automatic void release_escape();
    if (esc_phase != ESC_NONE) begin
      put_byte(CH_PCT);
    end
    if (esc_phase == ESC_DIGIT) begin
      put_byte(held_char);
    end
    esc_phase = ESC_NONE;
    held_char = 8'h00;
  endfunction

  function automatic void close_pair();
    expected_results.push_back('{data: 8'h00, data_valid: 1'b0, in_value: 1'b0,
                                 pair_end: 1'b1, had_equals: in_value_part, last: 1'b0});
    in_value_part = 1'b0;
  endfunction

  function automatic void decode_item(input logic op, input logic [7:0] b);
    int         base;
    logic [4:0] cur;
    logic [4:0] first;
    logic       taken;
    decoded_t   tail;
    base = expected_results.size();
    cur = hex_digit(b);
    first = hex_digit(held_char);
    taken = 1'b0;
    if (op == OP_END) begin
      release_escape();
      close_pair();
    end else begin
      if (esc_phase == ESC_PCT && cur[4]) begin
        held_char = b;
        esc_phase = ESC_DIGIT;
        taken = 1'b1;
      end else if (esc_phase == ESC_DIGIT && cur[4]) begin
        put_byte({first[3:0], cur[3:0]});
        esc_phase = ESC_NONE;
        held_char = 8'h00;
        taken = 1'b1;
      end else begin
        release_escape();
      end
      if (!taken) begin
        if (b == CH_PCT) begin
          esc_phase = ESC_PCT;
        end else if (b == CH_PLUS) begin
          put_byte(CH_SPACE);
        end else if (b == CH_AMP) begin
          close_pair();
        end else if (b == CH_EQ && !in_value_part) begin
          in_value_part = 1'b1;
        end else begin
          put_byte(b);
        end
      end
    end
    // Tag the final result of this item.
    if (expected_results.size() > base) begin
      tail = expected_results.pop_back();
      tail.last = 1'b1;
      expected_results.push_back(tail);
    end
  endfunction

  always @(posedge clk) begin
    decoded_t seen;
    decoded_t want;
    if (rst) begin
      esc_phase = ESC_NONE;
      held_char = 8'h00;
      in_value_part = 1'b0;
      expected_results.delete();
    end else begin
      if (query.valid && query.ready) begin
        decode_item(query.op, query.raw_byte);
      end
      if (result.valid && result.ready) begin
        seen = '{data: result.data, data_valid: result.data_valid, in_value: result.in_value,
                 pair_end: result.pair_end, had_equals: result.had_equals,
                 last: result.last};
        if (expected_results.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result: data=%02h dv=%b in_value=%b pair_end=%b eq=%b last=%b",
                   $time, seen.data, seen.data_valid, seen.in_value, seen.pair_end,
                   seen.had_equals, seen.last);
        end else begin
          want = expected_results.pop_front();
          if (seen !== want) begin
            mismatches++;
            $display("%0t: expected data=%02h dv=%b in_value=%b pair_end=%b eq=%b last=%b",
                     $time, want.data, want.data_valid, want.in_value, want.pair_end,
                     want.had_equals, want.last);
            $display("%0t:   actual data=%02h dv=%b in_value=%b pair_end=%b eq=%b last=%b",
                     $time, seen.data, seen.data_valid, seen.in_value, seen.pair_end,
                     seen.had_equals, seen.last);
          end
        end
      end
    end
    pending = expected_results.size();
  end

endmodule

/* verif/testbench.sv */
// Top of the query string decoder testbench: clock, reset, stimulus and verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import uqd_pkg::*;

  localparam int ITEMS_PER_PHASE = 150;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int HOLDOFF_CYCLES  = 60;

  logic clk;
  logic rst;
  int   mismatches;
  int   pending;
  int   cycles = 0;
  int   sent = 0;
  int   snd_idle_pct = 0;
  int   rcv_idle_pct = 0;
  int   stall_left = 0;
  bit   hold_req = 1'b0;

  uqd_in_if  query_ch ();
  uqd_out_if result_ch ();

  urlencoded_query_decoder_top dut (
    .clk    (clk),
    .rst    (rst),
    .query  (query_ch),
    .result (result_ch)
  );

  query_decode_checker scoreboard (
    .clk        (clk),
    .rst        (rst),
    .query      (query_ch),
    .result     (result_ch),
    .mismatches (mismatches),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Result side: random back-pressure, plus a long hold-off on request.
  initial begin
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        stall_left = HOLDOFF_CYCLES;
        hold_req = 1'b0;
      end
      if (stall_left > 0) begin
        stall_left--;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
      end
    end
  end

  // Call at a falling edge; returns at the falling edge after the item is taken.
  task automatic push_item(input logic op, input logic [7:0] b);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      query_ch.valid <= 1'b0;
      @(negedge clk);
    end
    query_ch.valid <= 1'b1;
    query_ch.op <= op;
    query_ch.raw_byte <= b;
    @(posedge clk);
    while (!query_ch.ready) @(posedge clk);
    sent++;
    @(negedge clk);
  endtask

  task automatic push_byte(input logic [7:0] b);
    push_item(OP_BYTE, b);
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      push_byte(s[i]);
    end
  endtask

  function automatic logic [7:0] hex_char();
    int v;
    v = $urandom_range(0, 21);
    if (v < 10) return 8'(8'h30 + v);
    if (v < 16) return 8'(8'h41 + v - 10);
    return 8'(8'h61 + v - 16);
  endfunction

  task automatic send_piece();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      push_byte(CH_PCT);
      push_byte(hex_char());
      push_byte(hex_char());
    end else if (pick < 27) begin
      // broken escape: '%', maybe one digit, then anything
      push_byte(CH_PCT);
      if ($urandom_range(0, 1) == 1) begin
        push_byte(hex_char());
      end
      push_byte(8'($urandom));
    end else if (pick < 37) begin
      push_byte(CH_PLUS);
    end else if (pick < 42) begin
      push_byte(CH_EQ);
    end else if (pick < 55) begin
      push_byte(8'($urandom));
    end else begin
      push_byte(8'($urandom_range(8'h61, 8'h7A)));
    end
  endtask

  task automatic send_query();
    int pairs;
    pairs = $urandom_range(0, 4);
    for (int p = 0; p < pairs; p++) begin
      if (p > 0) begin
        push_byte(CH_AMP);
      end
      repeat ($urandom_range(0, 5)) send_piece();
      if ($urandom_range(0, 99) < 80) begin
        push_byte(CH_EQ);
      end
      repeat ($urandom_range(0, 5)) send_piece();
    end
    if ($urandom_range(0, 9) == 0) begin
      push_byte(CH_AMP);
    end
    push_item(OP_END, 8'($urandom));
  endtask

  task automatic send_noise();
    repeat ($urandom_range(1, 12)) begin
      push_item(($urandom_range(0, 7) == 0) ? OP_END : OP_BYTE, 8'($urandom));
    end
  endtask

  task automatic run_phase(input int snd_pct, input int rcv_pct, input bit with_holdoff);
    int target;
    target = sent + ITEMS_PER_PHASE;
    snd_idle_pct = snd_pct;
    rcv_idle_pct = rcv_pct;
    if (with_holdoff) begin
      hold_req = 1'b1;
    end
    while (sent < target) begin
      if ($urandom_range(0, 9) == 0) begin
        send_noise();
      end else begin
        send_query();
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    query_ch.valid = 1'b0;
    query_ch.op = OP_BYTE;
    query_ch.raw_byte = 8'h00;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: empty query with a stray byte on the end item, byte extremes,
    // repeated '=', '+', escapes in both cases, malformed escapes, an escape
    // cut by '&', a double '%', and an escape left open at the end.
    push_item(OP_END, 8'hFF);
    push_byte(8'h00);
    push_byte(8'hFF);
    push_text("==+%4a%Ff%g%3&%%=&%7");
    push_item(OP_END, 8'h00);

    run_phase(34, 48, 1'b0);
    run_phase(48, 34, 1'b0);
    run_phase(0, 0, 1'b1);

    query_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/uqd_pkg.sv
hdl/uqd_if.sv
hdl/uqd_decode.sv
hdl/urlencoded_query_decoder_top.sv
verif/query_decode_checker.sv
verif/testbench.sv
